@@ sv/ttcs_pkg.sv @@
package ttcs_pkg;

  // Default sizes
  localparam int CAPACITY_DEF  = 16;
  localparam int MAX_BYTES_DEF = 64;
  localparam int ID_BYTES_DEF  = 4;

  // Fixed field widths
  localparam int LW  = 7;
  localparam int TW  = 32;
  localparam int INW = 80;
  localparam int OUTW = 88;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_FIND   = 3'd2,
    ACT_POP    = 3'd3,
    ACT_CLEAR  = 3'd4,
    ACT_SET_EN = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOTHING   = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_DUP       = 3'd4,
    ST_FULL      = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_RX_SMALL  = 3'd7
  } st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_EVAL,
    S_COPY_RD,
    S_COPY_WR,
    S_STR_RD,
    S_STR_OUT,
    S_MOVE,
    S_MV_REC_WR,
    S_MV_RD,
    S_MV_WR,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic stage;
    logic scan_start;
    logic scan_rd;
    logic scan_cmp;
    logic set_status;
    st_t  status;
    logic emit_single;
    logic clear;
    logic set_en;
    logic rec_write_new;
    logic copy_rd;
    logic copy_wr;
    logic commit_insert;
    logic commit_remove;
    logic mv_rec_rd;
    logic mv_rec_wr;
    logic mv_rd;
    logic mv_wr;
    logic str_rd;
    logic str_out;
    logic j_clear;
  } ttcs_cmd_t;

  typedef struct packed {
    act_t act;
    logic tlast;
    logic enabled;
    logic found;
    logic match;
    logic scan_done;
    logic len_short;
    logic len_long;
    logic count_full;
    logic cap_small;
    logic copy_last;
    logic str_last;
    logic mv_last;
    logic hit_is_last;
    logic out_free;
  } ttcs_sts_t;

endpackage

@@ sv/ttcs_ctrl.sv @@
module ttcs_ctrl import ttcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ttcs_sts_t sts,
  output ttcs_cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.act)
          ACT_INSERT: state_next = sts.tlast ? S_CHECK : S_IDLE;
          ACT_DELETE, ACT_FIND: state_next = S_SCAN_RD;
          ACT_POP: state_next = sts.enabled ? S_SCAN_RD : S_EMIT;
          default: state_next = S_EMIT;
        endcase
      end
      S_CHECK: begin
        state_next = (sts.len_short || sts.len_long) ? S_EMIT : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        state_next = sts.scan_done ? S_EVAL : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_next = (sts.match && sts.act != ACT_POP) ? S_EVAL : S_SCAN_RD;
      end
      S_EVAL: begin
        unique case (sts.act)
          ACT_INSERT: state_next = (sts.found || sts.count_full) ? S_EMIT : S_COPY_RD;
          ACT_DELETE: state_next = sts.found ? S_MOVE : S_EMIT;
          ACT_FIND:   state_next = sts.found ? S_STR_RD : S_EMIT;
          ACT_POP:    state_next = (!sts.found || sts.cap_small) ? S_EMIT : S_STR_RD;
          default:    state_next = S_EMIT;
        endcase
      end
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: state_next = sts.copy_last ? S_EMIT : S_COPY_RD;
      S_STR_RD:  state_next = S_STR_OUT;
      S_STR_OUT: begin
        if (sts.out_free) begin
          if (!sts.str_last) state_next = S_STR_RD;
          else state_next = (sts.act == ACT_POP) ? S_MOVE : S_IDLE;
        end
      end
      S_MOVE: begin
        if (sts.hit_is_last) state_next = (sts.act == ACT_DELETE) ? S_EMIT : S_IDLE;
        else state_next = S_MV_REC_WR;
      end
      S_MV_REC_WR: state_next = S_MV_RD;
      S_MV_RD:     state_next = S_MV_WR;
      S_MV_WR: begin
        if (sts.mv_last) state_next = (sts.act == ACT_DELETE) ? S_EMIT : S_IDLE;
        else state_next = S_MV_RD;
      end
      S_EMIT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        unique case (sts.act)
          ACT_INSERT: cmd.stage = 1'b1;
          ACT_DELETE, ACT_FIND: cmd.scan_start = 1'b1;
          ACT_POP: begin
            if (sts.enabled) begin
              cmd.scan_start = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOTHING;
            end
          end
          ACT_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
          end
          ACT_SET_EN: begin
            cmd.set_en     = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
          end
        endcase
      end
      S_CHECK: begin
        priority if (sts.len_short) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BAD_LEN;
        end else if (sts.len_long) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_TOO_LARGE;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN_RD:  cmd.scan_rd = !sts.scan_done;
      S_SCAN_CMP: cmd.scan_cmp = 1'b1;
      S_EVAL: begin
        unique case (sts.act)
          ACT_INSERT: begin
            priority if (sts.found) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DUP;
            end else if (sts.count_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else begin
              cmd.rec_write_new = 1'b1;
              cmd.j_clear       = 1'b1;
            end
          end
          ACT_DELETE: begin
            if (sts.found) begin
              cmd.commit_remove = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
            end
          end
          ACT_FIND: begin
            if (sts.found) begin
              cmd.j_clear = 1'b1;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOT_FOUND;
            end
          end
          ACT_POP: begin
            priority if (!sts.found) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NOTHING;
            end else if (sts.cap_small) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RX_SMALL;
            end else begin
              cmd.commit_remove = 1'b1;
              cmd.j_clear       = 1'b1;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
          end
        endcase
      end
      S_COPY_RD: cmd.copy_rd = 1'b1;
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (sts.copy_last) begin
          cmd.commit_insert = 1'b1;
          cmd.set_status    = 1'b1;
          cmd.status        = ST_OK;
        end
      end
      S_STR_RD:  cmd.str_rd = 1'b1;
      S_STR_OUT: cmd.str_out = sts.out_free;
      S_MOVE: begin
        if (sts.hit_is_last) begin
          cmd.set_status = (sts.act == ACT_DELETE);
          cmd.status     = ST_OK;
        end else begin
          cmd.mv_rec_rd = 1'b1;
        end
      end
      S_MV_REC_WR: begin
        cmd.mv_rec_wr = 1'b1;
        cmd.j_clear   = 1'b1;
      end
      S_MV_RD: cmd.mv_rd = 1'b1;
      S_MV_WR: begin
        cmd.mv_wr = 1'b1;
        if (sts.mv_last) begin
          cmd.set_status = (sts.act == ACT_DELETE);
          cmd.status     = ST_OK;
        end
      end
      S_EMIT: cmd.emit_single = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/ttcs_dp.sv @@
module ttcs_dp import ttcs_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int MAX_BYTES = MAX_BYTES_DEF,
  parameter int ID_BYTES  = ID_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ttcs_cmd_t         cmd,
  output ttcs_sts_t         sts,
  input  logic [INW-1:0]    s_tdata,
  input  logic [2:0]        s_tuser,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUTW-1:0]   m_tdata,
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);

  localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int BW    = $clog2(MAX_BYTES);
  localparam int AW    = IW + BW;
  localparam int BDEPTH = CAPACITY * (2 ** BW);
  localparam int IDW   = 8 * ID_BYTES;
  localparam int RW    = IDW + TW + LW;

  // Latched input transaction
  act_t          act;
  logic [TW-1:0] tval;
  logic [7:0]    tbyte;
  logic          tlast;
  logic [TW-1:0] rid;
  logic [LW-1:0] cap;
  logic          en;

  // Control state
  logic [CW-1:0] count;
  logic          enabled;
  logic [TW-1:0] gen;
  logic [LW-1:0] stage_len;

  // Working registers
  logic [IDW-1:0] stage_id;
  logic [LW-1:0]  fin_len;
  logic [CW-1:0]  scan_i;
  logic           found;
  logic [IW-1:0]  hit;
  logic [TW-1:0]  hit_rel;
  logic [LW-1:0]  hit_len;
  logic [LW-1:0]  mv_len;
  logic [LW-1:0]  j;
  st_t            res_status;

  // Memories
  logic [RW-1:0] rec_mem [CAPACITY];
  logic [7:0]    byte_mem [BDEPTH];
  logic [7:0]    stage_mem [MAX_BYTES];
  logic [RW-1:0] rec_rd;
  logic [7:0]    byte_rd;
  logic [7:0]    stage_rd;

  // Output register
  logic [7:0]    o_byte;
  logic [LW-1:0] o_len;
  logic [TW-1:0] o_rel;
  logic [4:0]    o_total;
  logic [TW-1:0] o_gen;
  logic          o_en;
  st_t           o_status;
  logic          o_last;

  logic [IDW-1:0] key;
  logic [IDW-1:0] rec_id;
  logic [TW-1:0]  rec_rel;
  logic [LW-1:0]  rec_len;
  logic           key_eq;
  logic           pop_better;
  logic [LW-1:0]  jp1;
  logic [LW-1:0]  cap_sat;
  logic [LW-1:0]  stage_len_next;
  logic           out_free;
  logic           emit;

  assign rec_id  = rec_rd[RW-1 -: IDW];
  assign rec_rel = rec_rd[LW +: TW];
  assign rec_len = rec_rd[LW-1:0];
  assign key     = (act == ACT_INSERT) ? stage_id : rid[IDW-1:0];
  assign key_eq  = (rec_id == key);
  assign pop_better = (rec_rel <= tval) && (!found || rec_rel < hit_rel);
  assign jp1     = j + LW'(1);
  assign cap_sat = (cap > LW'(MAX_BYTES)) ? LW'(MAX_BYTES) : cap;
  assign stage_len_next = (stage_len <= LW'(MAX_BYTES)) ? stage_len + LW'(1) : stage_len;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = cmd.emit_single || cmd.str_out;

  // Status to the controller
  always_comb begin
    sts.act         = act;
    sts.tlast       = tlast;
    sts.enabled     = enabled;
    sts.found       = found;
    sts.match       = key_eq;
    sts.scan_done   = (scan_i >= count);
    sts.len_short   = (fin_len < LW'(ID_BYTES));
    sts.len_long    = (fin_len > LW'(MAX_BYTES));
    sts.count_full  = (count >= CW'(CAPACITY));
    sts.cap_small   = (cap_sat < hit_len);
    sts.copy_last   = (jp1 == fin_len);
    sts.str_last    = (jp1 == hit_len);
    sts.mv_last     = (jp1 == mv_len);
    sts.hit_is_last = (CW'(hit) == count);
    sts.out_free    = out_free;
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act   <= act_t'(s_tuser);
      tval  <= s_tdata[31:0];
      tbyte <= s_tdata[39:32];
      tlast <= s_tlast;
      rid   <= s_tdata[71:40];
      cap   <= s_tdata[78:72];
      en    <= s_tdata[79];
    end
  end

  // Table occupancy, enable and generation count
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      enabled <= 1'b0;
      gen     <= '0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        gen   <= gen + TW'(1);
      end
      if (cmd.set_en && (en != enabled)) begin
        enabled <= en;
        gen     <= gen + TW'(1);
      end
      if (cmd.commit_insert) begin
        count <= count + CW'(1);
        gen   <= gen + TW'(1);
      end
      if (cmd.commit_remove) begin
        count <= count - CW'(1);
        gen   <= gen + TW'(1);
      end
    end
  end

  // Staging of insert bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_len <= '0;
    end else if (cmd.stage) begin
      stage_len <= tlast ? '0 : stage_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage) begin
      if (stage_len < LW'(MAX_BYTES)) stage_mem[stage_len[BW-1:0]] <= tbyte;
      for (int k = 0; k < ID_BYTES; k++) begin
        if (stage_len == LW'(k)) stage_id[(ID_BYTES-1-k)*8 +: 8] <= tbyte;
      end
      if (tlast) fin_len <= stage_len_next;
    end
    if (cmd.copy_rd) stage_rd <= stage_mem[j[BW-1:0]];
  end

  // Scan, hit capture and byte counter
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_i <= '0;
      found  <= 1'b0;
    end
    if (cmd.scan_cmp) begin
      scan_i <= scan_i + CW'(1);
      if ((act == ACT_POP) ? pop_better : key_eq) begin
        found   <= 1'b1;
        hit     <= scan_i[IW-1:0];
        hit_rel <= rec_rel;
        hit_len <= rec_len;
      end
    end
    if (cmd.mv_rec_wr) mv_len <= rec_len;
    if (cmd.j_clear) j <= '0;
    else if (cmd.copy_wr || cmd.str_out || cmd.mv_wr) j <= jp1;
    if (cmd.set_status) res_status <= cmd.status;
  end

  // Record memory
  always_ff @(posedge clk) begin
    if (cmd.rec_write_new) rec_mem[count[IW-1:0]] <= {stage_id, tval, fin_len};
    else if (cmd.mv_rec_wr) rec_mem[hit] <= rec_rd;
    if (cmd.scan_rd) rec_rd <= rec_mem[scan_i[IW-1:0]];
    else if (cmd.mv_rec_rd) rec_rd <= rec_mem[count[IW-1:0]];
  end

  // Command byte memory
  always_ff @(posedge clk) begin
    if (cmd.copy_wr) byte_mem[AW'({count[IW-1:0], j[BW-1:0]})] <= stage_rd;
    else if (cmd.mv_wr) byte_mem[AW'({hit, j[BW-1:0]})] <= byte_rd;
    if (cmd.str_rd) byte_rd <= byte_mem[AW'({hit, j[BW-1:0]})];
    else if (cmd.mv_rd) byte_rd <= byte_mem[AW'({count[IW-1:0], j[BW-1:0]})];
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_total <= 5'(count);
      o_gen   <= gen;
      o_en    <= enabled;
      if (cmd.str_out) begin
        o_byte   <= byte_rd;
        o_len    <= hit_len;
        o_rel    <= hit_rel;
        o_status <= ST_OK;
        o_last   <= sts.str_last;
      end else begin
        o_byte   <= '0;
        o_len    <= '0;
        o_rel    <= '0;
        o_status <= res_status;
        o_last   <= 1'b1;
      end
    end
  end

  assign m_tdata = {3'b000, o_en, o_gen, o_total, o_rel, o_len, o_byte};
  assign m_tuser = o_status;
  assign m_tlast = o_last;

endmodule

@@ sv/time_tagged_command_scheduler.sv @@
// Each insert byte passes idle and decode; a lookup scans each entry by
// read and compare states; find and pop stream bytes by read and output
// states; a store copies and removal moves the last entry byte by byte.
// Throughput: one transaction at a time, set by the single-port scan and
// byte copy loops. Reset clears entry count, enable, generation count and
// staging length; stored commands are undefined and need no clearing pass.
module time_tagged_command_scheduler import ttcs_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int MAX_BYTES = MAX_BYTES_DEF,
  parameter int ID_BYTES  = ID_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  // time_value[31:0], tc_byte[39:32], cmd_id[71:40],
  // out_capacity[78:72], enable_value[79]
  input  logic [INW-1:0]  s_tdata,
  input  logic [2:0]      s_tuser,  // action
  input  logic            s_tlast,  // tc_last
  output logic            m_tvalid,
  input  logic            m_tready,
  // out_byte[7:0], out_length[14:8], out_release[46:15], entry_total[51:47],
  // change_count[83:52], enabled_now[84], zero pad[87:85]
  output logic [OUTW-1:0] m_tdata,
  output logic [2:0]      m_tuser,  // status
  output logic            m_tlast   // out_last
);

  ttcs_cmd_t cmd;
  ttcs_sts_t sts;

  ttcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttcs_dp #(
    .CAPACITY  (CAPACITY),
    .MAX_BYTES (MAX_BYTES),
    .ID_BYTES  (ID_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_single || cmd.str_out) |-> sts.out_free)
    else $error("result loaded over an untaken result");
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[51:47] <= 5'(CAPACITY)))
    else $error("entry total above capacity");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.str_out || cmd.copy_wr || cmd.mv_wr))
    else $error("accepting while a transaction is in progress");
`endif

endmodule
